### design/cwvr_pkg.sv
// Package for the coordinated wheel velocity ramp core.
// Holds the sequencer state type and the shared field widths; no dependencies.
package cwvr_pkg;

    localparam int unsigned VEL_W   = 16;
    localparam int unsigned DT_W    = 20;
    localparam int unsigned ACCEL_W = 23;
    localparam int unsigned MASK_W  = 3;
    localparam int unsigned WHEELS  = 3;

    // Register indexes on the configuration port.
    localparam logic REG_ACCEL_RATE  = 1'b0;
    localparam logic REG_INVERT_MASK = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIMIT,
        S_CMP,
        S_MUL,
        S_DIV,
        S_UPD,
        S_DONE
    } t_state;

endpackage

### design/coordinated_wheel_velocity_ramp_core.sv
// Top level of the coordinated wheel velocity ramp core.
// Depends on cwvr_pkg; the whole datapath lives in this one module.
//
// Usage:
//   Input words arrive on s_axis: three target velocities (Q5.10) and the period
//   length in microseconds. Each word yields exactly one output word on m_axis:
//   the three new wheel velocities after the ramp and the invert bits, with
//   tuser flagging that the acceleration limit scaled the step down.
//   accel_rate and invert_mask are written on the cfg port while the core idles.
//   A scaled word runs S_LIMIT, S_CMP, then S_MUL, S_DIV and S_UPD per wheel and
//   S_DONE; when every wheel jumps to its target, S_CMP goes straight to S_DONE.
//   One shared multiplier forms the period limit and then each wheel's product,
//   and one restoring divider step takes one quotient bit per cycle, so the three
//   wheel divisions take most of a scaled word's time. s_axis_tready is high only
//   between words, so the core takes no new word until the last one is finished.
//   The finished word sits in an output register; the core accepts the next
//   input while it waits, and holds the following result until it is taken.
//   A synchronous active-low reset zeroes the stored velocities and both
//   registers and drops m_axis_tvalid.
module coordinated_wheel_velocity_ramp_core
    import cwvr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [ACCEL_W-1:0]   i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // target_front[15:0], target_left[31:16], target_right[47:32], dt_us[67:48]
    input  logic [71:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // drive_front[15:0], drive_left[31:16], drive_right[47:32]
    output logic [47:0]          m_axis_tdata,
    // limited[0]
    output logic                 m_axis_tuser
);

    t_state r_state, n_state;

    logic [ACCEL_W-1:0]       r_accel;
    logic [MASK_W-1:0]        r_invert;
    logic signed [VEL_W-1:0]  r_vel  [WHEELS];
    logic signed [VEL_W-1:0]  r_tgt  [WHEELS];
    logic signed [VEL_W:0]    r_diff [WHEELS];
    logic [DT_W-1:0]          r_dt;
    logic [VEL_W-1:0]         r_maxd;
    logic [VEL_W-1:0]         r_limit;
    logic [DT_W+ACCEL_W-1:0]  r_prod;
    logic                     r_scaled;
    logic [1:0]               r_wheel;
    logic [3:0]               r_cnt;
    logic [47:0]              r_out_data;
    logic                     r_out_lim;
    logic                     r_out_valid;

    logic                     in_fire;
    logic                     out_free;
    logic [DT_W-1:0]          mul_a;
    logic [ACCEL_W-1:0]       mul_b;
    logic [DT_W+ACCEL_W-1:0]  mul_p;
    logic [VEL_W-1:0]         mag [WHEELS];
    logic [VEL_W-1:0]         max01;
    logic [VEL_W-1:0]         max012;
    logic [ACCEL_W-1:0]       limit_full;
    logic                     over_limit;
    logic [VEL_W:0]           div_shift;
    logic [VEL_W:0]           div_trial;
    logic                     div_ge;
    logic signed [VEL_W-1:0]  step;

    function automatic logic [VEL_W-1:0] f_abs(input logic signed [VEL_W:0] d);
        logic signed [VEL_W:0] n;
        n = -d;
        return d[VEL_W] ? n[VEL_W-1:0] : d[VEL_W-1:0];
    endfunction

    // Negation on the output saturates the most negative velocity.
    function automatic logic [VEL_W-1:0] f_out(input logic signed [VEL_W-1:0] v,
                                               input logic inv);
        logic signed [VEL_W-1:0] n;
        n = -v;
        if (!inv) begin
            return v;
        end else if (v == {1'b1, {(VEL_W-1){1'b0}}}) begin
            return {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            return n;
        end
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_lim;

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            mag[i] = f_abs(r_diff[i]);
        end
        max01  = (mag[1] > mag[0]) ? mag[1] : mag[0];
        max012 = (mag[2] > max01) ? mag[2] : max01;
    end

    // The one multiplier: period limit first, then one wheel product at a time.
    always_comb begin
        if (r_state == S_LIMIT) begin
            mul_a = r_dt;
            mul_b = r_accel;
        end else begin
            mul_a = {{(DT_W-VEL_W){1'b0}}, mag[r_wheel]};
            mul_b = {{(ACCEL_W-VEL_W){1'b0}}, r_limit};
        end
        mul_p = (DT_W+ACCEL_W)'(mul_a) * (DT_W+ACCEL_W)'(mul_b);
    end

    assign limit_full = r_prod[DT_W+ACCEL_W-1:20];
    assign over_limit = {{(ACCEL_W-VEL_W){1'b0}}, r_maxd} > limit_full;

    // Restoring divider step: remainder in r_prod[31:16], quotient shifts in below.
    assign div_shift = {r_prod[2*VEL_W-1:VEL_W], r_prod[VEL_W-1]};
    assign div_trial = div_shift - {1'b0, r_maxd};
    assign div_ge    = (div_shift >= {1'b0, r_maxd});

    always_comb begin
        step = r_prod[VEL_W-1:0];
        if (r_diff[r_wheel][VEL_W]) begin
            step = -r_prod[VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_LIMIT;
            end
            S_LIMIT: n_state = S_CMP;
            S_CMP: begin
                n_state = over_limit ? S_MUL : S_DONE;
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 4'hF) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = (r_wheel == 2'(WHEELS-1)) ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel  <= '0;
            r_invert <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ACCEL_RATE:  r_accel  <= i_cfg_wdata;
                REG_INVERT_MASK: r_invert <= i_cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WHEELS; i++) begin
                r_vel[i] <= '0;
            end
            r_out_valid <= 1'b0;
            r_wheel     <= '0;
            r_cnt       <= '0;
            r_scaled    <= 1'b0;
        end else begin
            // A word loaded in S_DONE replaces the one leaving in the same cycle.
            if (r_out_valid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_tgt[0] <= s_axis_tdata[15:0];
                        r_tgt[1] <= s_axis_tdata[31:16];
                        r_tgt[2] <= s_axis_tdata[47:32];
                        r_dt     <= s_axis_tdata[67:48];
                        r_diff[0] <= {s_axis_tdata[15], s_axis_tdata[15:0]}
                                     - {r_vel[0][VEL_W-1], r_vel[0]};
                        r_diff[1] <= {s_axis_tdata[31], s_axis_tdata[31:16]}
                                     - {r_vel[1][VEL_W-1], r_vel[1]};
                        r_diff[2] <= {s_axis_tdata[47], s_axis_tdata[47:32]}
                                     - {r_vel[2][VEL_W-1], r_vel[2]};
                    end
                end
                S_LIMIT: begin
                    r_prod <= mul_p;
                    r_maxd <= max012;
                end
                S_CMP: begin
                    r_scaled <= over_limit;
                    r_limit  <= limit_full[VEL_W-1:0];
                    r_wheel  <= '0;
                    if (!over_limit) begin
                        for (int i = 0; i < WHEELS; i++) begin
                            r_vel[i] <= r_tgt[i];
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= mul_p;
                    r_cnt  <= '0;
                end
                S_DIV: begin
                    r_cnt  <= r_cnt + 4'd1;
                    r_prod <= {{(DT_W+ACCEL_W-2*VEL_W){1'b0}},
                               div_ge ? div_trial[VEL_W-1:0] : div_shift[VEL_W-1:0],
                               r_prod[VEL_W-2:0], div_ge};
                end
                S_UPD: begin
                    r_vel[r_wheel] <= r_vel[r_wheel] + step;
                    r_wheel        <= r_wheel + 2'd1;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {f_out(r_vel[2], r_invert[2]),
                                        f_out(r_vel[1], r_invert[1]),
                                        f_out(r_vel[0], r_invert[0])};
                        r_out_lim   <= r_scaled;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### design/cwvr_checker.sv
// Port-level checker for the coordinated wheel velocity ramp core.
// Depends on nothing but the top level's ports; bound to it at the end of this file.
module cwvr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_cfg_index,
    input logic [22:0] i_cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // The core works on one word at a time, so it closes its input after a take.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready right after a word was taken");

    // A stalled result holds its value and flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    // Reset leaves no result pending and the input open.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("core not empty after reset");

    // A new result shows up exactly as the sequencer returns to idle.
    a_result_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result appeared while the core was still busy");

endmodule

bind coordinated_wheel_velocity_ramp_core cwvr_checker u_cwvr_checker (.*);

### tb/testbench.sv
// Self-checking testbench for coordinated_wheel_velocity_ramp_core.
// Depends on cwvr_pkg and the core; it drives random and directed words and checks
// every output word against an in-bench predictor of the ramp.
`timescale 1ns / 1ps

module testbench;
    import cwvr_pkg::*;

    localparam int unsigned LATENCY     = 58;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASE_WORDS = 100;

    typedef struct {
        logic [15:0] drive [WHEELS];
        logic        limited;
    } t_drive_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_index = REG_ACCEL_RATE;
    logic [ACCEL_W-1:0]   i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // target_front[15:0], target_left[31:16], target_right[47:32], dt_us[67:48]
    logic [71:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // drive_front[15:0], drive_left[31:16], drive_right[47:32]
    logic [47:0]          m_axis_tdata;
    // limited[0]
    logic                 m_axis_tuser;

    coordinated_wheel_velocity_ramp_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: stored wheel velocities before inversion, and register copies.
    logic signed [15:0]   wheel_vel [WHEELS] = '{default: '0};
    logic [ACCEL_W-1:0]   accel_rate = '0;
    logic [MASK_W-1:0]    invert_mask = '0;

    logic [71:0]          word_queue [$];
    t_drive_word          drive_expected [$];
    int unsigned          words_sent = 0;
    int unsigned          words_taken = 0;
    int unsigned          src_idle_pct = 0;
    int unsigned          sink_stall_pct = 0;
    int unsigned          err_count = 0;
    int unsigned          cycle_count = 0;

    function automatic t_drive_word ramp_step(input logic [71:0] word);
        t_drive_word        res;
        logic signed [15:0] tgt [WHEELS];
        logic [63:0]        lim;
        logic [63:0]        max_mag;
        logic [63:0]        mag;
        logic [63:0]        quo;
        int                 diff [WHEELS];
        int                 v;
        tgt[0] = word[15:0];
        tgt[1] = word[31:16];
        tgt[2] = word[47:32];
        lim = (64'(word[67:48]) * 64'(accel_rate)) >> 20;
        max_mag = '0;
        for (int i = 0; i < WHEELS; i++) begin
            diff[i] = int'(tgt[i]) - int'(wheel_vel[i]);
            mag = (diff[i] < 0) ? 64'(-diff[i]) : 64'(diff[i]);
            if (mag > max_mag) max_mag = mag;
        end
        res.limited = (max_mag > lim);
        for (int i = 0; i < WHEELS; i++) begin
            if (res.limited) begin
                // Proportional step keeps the direction of the velocity vector.
                mag = (diff[i] < 0) ? 64'(-diff[i]) : 64'(diff[i]);
                quo = (mag * lim) / max_mag;
                if (diff[i] < 0) wheel_vel[i] = wheel_vel[i] - 16'(quo);
                else wheel_vel[i] = wheel_vel[i] + 16'(quo);
            end else begin
                wheel_vel[i] = tgt[i];
            end
            v = int'(wheel_vel[i]);
            if (invert_mask[i]) begin
                v = -v;
                if (v > 32767) v = 32767;
            end
            res.drive[i] = v[15:0];
        end
        return res;
    endfunction

    // Driver: a word stays on the bus until it has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && words_taken != words_sent) begin
            s_axis_tvalid <= 1'b1;
        end else if (word_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            s_axis_tdata  <= word_queue.pop_front();
            s_axis_tvalid <= 1'b1;
            words_sent++;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            words_taken++;
            drive_expected.push_back(ramp_step(s_axis_tdata));
        end
    end

    // Monitor: every output word is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_drive_word exp_word;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drive_expected.size() == 0) begin
                $display("%0t: unexpected word drive=%h limited=%b", $time,
                         m_axis_tdata, m_axis_tuser);
                err_count++;
            end else begin
                exp_word = drive_expected.pop_front();
                for (int i = 0; i < WHEELS; i++) begin
                    if (m_axis_tdata[16*i +: 16] !== exp_word.drive[i]) begin
                        $display("%0t: wheel %0d expected %h actual %h", $time, i,
                                 exp_word.drive[i], m_axis_tdata[16*i +: 16]);
                        err_count++;
                    end
                end
                if (m_axis_tuser !== exp_word.limited) begin
                    $display("%0t: limited expected %b actual %b", $time,
                             exp_word.limited, m_axis_tuser);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_word(input logic [15:0] front, input logic [15:0] left,
                            input logic [15:0] right, input logic [19:0] dt);
        word_queue.push_back({4'b0, dt, right, left, front});
    endtask

    task automatic write_reg(input logic index, input logic [ACCEL_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = value;
        if (index == REG_ACCEL_RATE) accel_rate = value;
        else invert_mask = value[MASK_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_drained(input int unsigned tail);
        while (word_queue.size() != 0 || s_axis_tvalid || drive_expected.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_velocity();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3, 4: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    function automatic logic [19:0] pick_period();
        case ($urandom_range(0, 15))
            0: return 20'd0;
            1: return 20'hFFFFF;
            2, 3: return 20'($urandom_range(0, 20'hFFFFF));
            default: return 20'($urandom_range(1, 2000));
        endcase
    endfunction

    initial begin
        logic [15:0] tgt [WHEELS];
        int unsigned hold_count;
        logic [ACCEL_W-1:0] rate_choice [8];
        tgt = '{default: '0};
        hold_count = 0;
        rate_choice = '{23'h7FFFFF, 23'd1 << 20, 23'd0, 23'd3 << 20,
                        23'd1 << 22, 23'd0, 23'd0, 23'd0};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Registers still at reset: zero limit holds every wheel, then no change.
        add_word(16'd1000, -16'sd1000, 16'd5, 20'd1000);
        add_word(16'd0, 16'd0, 16'd0, 20'd500);
        wait_drained(8);

        write_reg(REG_ACCEL_RATE, 23'h7FFFFF);
        write_reg(REG_INVERT_MASK, 23'd7);
        add_word(16'h7FFF, 16'h8000, 16'h0000, 20'hFFFFF);
        add_word(16'h8000, 16'h8000, 16'h8000, 20'hFFFFF);
        add_word(16'h8000, 16'h8000, 16'h8000, 20'd3);
        add_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 20'd0);
        add_word(16'h7FFF, 16'h0001, 16'hFFFF, 20'd1);
        wait_drained(8);

        write_reg(REG_ACCEL_RATE, 23'd1 << 20);
        write_reg(REG_INVERT_MASK, 23'd0);
        add_word(16'h7FFF, 16'h8000, 16'd100, 20'd100);
        add_word(16'h7FFF, 16'h8000, 16'd100, 20'd5000);
        add_word(-16'sd300, 16'd200, 16'd0, 20'd100);
        add_word(-16'sd300, 16'd200, 16'd0, 20'hFFFFF);
        add_word(-16'sd300, 16'd200, 16'd0, 20'd10);
        add_word(16'd7, -16'sd7, 16'd0, 20'd1);
        wait_drained(8);

        write_reg(REG_ACCEL_RATE, 23'd1);
        write_reg(REG_INVERT_MASK, 23'd2);
        add_word(16'h8000, 16'h7FFF, 16'h1234, 20'hFFFFF);
        add_word(16'h8000, 16'h7FFF, 16'h1234, 20'd0);
        wait_drained(8);

        rate_choice[5] = 23'($urandom_range(1, 255));
        rate_choice[6] = 23'($urandom_range(0, 23'h7FFFFF));
        rate_choice[7] = 23'($urandom_range(23'h10000, 23'h3FFFFF));
        for (int phase = 0; phase < 8; phase++) begin
            case (phase / 2)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 26; sink_stall_pct = 26; end
            endcase
            write_reg(REG_ACCEL_RATE, rate_choice[phase]);
            write_reg(REG_INVERT_MASK, (phase == 0) ? 23'd7 :
                      (phase == 2) ? 23'd0 : 23'($urandom_range(0, 7)));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Targets are held for a few periods so the wheels reach them.
                if (hold_count == 0) begin
                    for (int i = 0; i < WHEELS; i++) tgt[i] = pick_velocity();
                    hold_count = $urandom_range(1, 6);
                end
                hold_count--;
                add_word(tgt[0], tgt[1], tgt[2], pick_period());
            end
            wait_drained(8);
        end

        wait_drained(LATENCY + 20);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### coordinated_wheel_velocity_ramp_core.f
design/cwvr_pkg.sv
design/coordinated_wheel_velocity_ramp_core.sv
design/cwvr_checker.sv
tb/testbench.sv
